// ===== rtl/banded_priority_queue_unit_assert.svh =====
// Assertion macros used by the queue top module; clk and rst_n are taken from the
// module that uses them.
`ifndef BANDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BANDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpq assertion failed");
`define BPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpq assertion failed");
`else
`define BPQ_ASSERT_IMP(label, ante, cons)
`define BPQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/bpq_pkg.sv =====
`default_nettype none
package bpq_pkg;

    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 16;
    localparam int CLASS_W       = 3;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    localparam logic signed [PRIO_W-1:0] BAND2_MIN = 16'sd20;
    localparam logic signed [PRIO_W-1:0] BAND3_MIN = 16'sd40;
    localparam logic signed [PRIO_W-1:0] BAND4_MIN = 16'sd60;
    localparam logic signed [PRIO_W-1:0] BAND5_MIN = 16'sd80;

    typedef struct packed {
        logic [CLASS_W-1:0]        cls;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    // broadcast to every cell; ins/del already qualified by accept and fill state
    typedef struct packed {
        logic   ins;
        logic   del;
        entry_t item;
    } ctrl_t;

    function automatic logic [CLASS_W-1:0] band_of(input logic signed [PRIO_W-1:0] p);
        logic [CLASS_W-1:0] c;
        if (p < BAND2_MIN)
            c = 3'd1;
        else if (p < BAND3_MIN)
            c = 3'd2;
        else if (p < BAND4_MIN)
            c = 3'd3;
        else if (p < BAND5_MIN)
            c = 3'd4;
        else
            c = 3'd5;
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bpq_cell.sv =====
`default_nettype none
// One slot of the sorted chain. Entries are kept in descending class order,
// older first within a class, so the head is always the next to leave.
module bpq_cell (
    input  wire logic            clk,
    input  wire bpq_pkg::ctrl_t  ctrl,
    input  wire logic            live,
    input  wire logic            prev_keep,
    input  wire bpq_pkg::entry_t prev_entry,
    input  wire bpq_pkg::entry_t next_entry,
    output bpq_pkg::entry_t      entry,
    output logic                 keep
);

    bpq_pkg::entry_t entry_reg;
    bpq_pkg::entry_t entry_next;

    // an entry stays put when the new item ranks below or equal to it
    assign keep  = live && (entry_reg.cls >= ctrl.item.cls);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!keep)
                entry_next = prev_keep ? ctrl.item : prev_entry;
        end
        else if (ctrl.del)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

// ===== rtl/banded_priority_queue_unit.sv =====
`default_nettype none
// Channel | Dir | tdata (low bit up)                     | tuser
// s_*     | in  | item_value[31:0], raw_priority[47:32]   | cmd[0]
// m_*     | out | out_value[31:0], out_class[34:32]       | status[1:0]
//
// One request per cycle: each request updates the cell chain in the cycle it
// is taken; insert and delete are local neighbor moves, so DEPTH does not
// change the rate. The result shows in the next cycle from the output register.
// s_tready stays high while the output register is empty or being drained.
// Reset clears the entry count and output valid; no clearing pass is needed.
`include "banded_priority_queue_unit_assert.svh"
module banded_priority_queue_unit #(
    parameter int DEPTH = bpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // item_value, raw_priority
    input  wire logic [0:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_value, out_class, zero fill
    output logic [1:0]       m_tuser    // status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          m_tvalid_reg;
    logic          m_tvalid_next;
    bpq_pkg::status_t            status_reg;
    bpq_pkg::status_t            status_next;
    logic signed [bpq_pkg::VALUE_W-1:0] value_reg;
    logic signed [bpq_pkg::VALUE_W-1:0] value_next;
    logic [bpq_pkg::CLASS_W-1:0] class_reg;
    logic [bpq_pkg::CLASS_W-1:0] class_next;

    logic                         accept;
    logic                         cmd;
    logic                         full;
    logic                         empty;
    logic [bpq_pkg::CLASS_W-1:0]  new_class;
    bpq_pkg::ctrl_t               ctrl;
    bpq_pkg::entry_t              entry_q [DEPTH];
    logic                         keep    [DEPTH];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = s_tuser[0];
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign new_class = bpq_pkg::band_of(s_tdata[47:32]);

    assign ctrl.ins        = accept && (cmd == bpq_pkg::CMD_INSERT) && !full;
    assign ctrl.del        = accept && (cmd == bpq_pkg::CMD_DELETE) && !empty;
    assign ctrl.item.cls   = new_class;
    assign ctrl.item.value = s_tdata[31:0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic            prev_keep;
        bpq_pkg::entry_t prev_entry;
        bpq_pkg::entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_entry = ctrl.item;
        end
        else
        begin : g_body
            assign prev_keep  = keep[i-1];
            assign prev_entry = entry_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_entry = entry_q[i];
        end
        else
        begin : g_mid
            assign next_entry = entry_q[i+1];
        end

        bpq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .live       (CW'(i) < count_reg),
            .prev_keep  (prev_keep),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (entry_q[i]),
            .keep       (keep[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CW'(1);
        else if (ctrl.del)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        if (cmd == bpq_pkg::CMD_INSERT)
        begin
            status_next = full ? bpq_pkg::ST_FULL : bpq_pkg::ST_INSERTED;
            value_next  = '0;
            class_next  = new_class;
        end
        else if (empty)
        begin
            status_next = bpq_pkg::ST_EMPTY;
            value_next  = '0;
            class_next  = '0;
        end
        else
        begin
            status_next = bpq_pkg::ST_REMOVED;
            value_next  = entry_q[0].value;
            class_next  = entry_q[0].cls;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            class_reg  <= class_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {5'd0, class_reg, value_reg};

    `BPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `BPQ_ASSERT_IMP(a_head_sorted, count_reg >= CW'(2), entry_q[0].cls >= entry_q[1].cls)
    `BPQ_ASSERT_NXT(a_ins_grows, ctrl.ins, count_reg == $past(count_reg) + CW'(1))
    `BPQ_ASSERT_NXT(a_empty_report, accept && (cmd == bpq_pkg::CMD_DELETE) && empty,
                    m_tvalid && (m_tuser == bpq_pkg::ST_EMPTY) && (count_reg == '0))
    `BPQ_ASSERT_IMP(a_no_both, 1'b1, !(ctrl.ins && ctrl.del))

endmodule
`default_nettype wire

// ===== sim/bpq_checker.sv =====
`default_nettype none
module bpq_checker #(
    parameter int DEPTH = bpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // item_value, raw_priority
    input  wire logic [0:0]  s_tuser,   // cmd
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // out_value, out_class, zero fill
    input  wire logic [1:0]  m_tuser,   // status
    output int               errors,
    output int               pending
);

    typedef struct {
        bpq_pkg::status_t                   status;
        logic signed [bpq_pkg::VALUE_W-1:0] value;
        logic [bpq_pkg::CLASS_W-1:0]        cls;
    } queue_result_t;

    queue_result_t result_q [$];

    // shadow copy of the queue contents, oldest entry in slot 0
    logic signed [bpq_pkg::VALUE_W-1:0] held_value [DEPTH];
    logic [bpq_pkg::CLASS_W-1:0]        held_class [DEPTH];
    int                                 held_count;

    function automatic logic [bpq_pkg::CLASS_W-1:0] class_of(
        input logic signed [bpq_pkg::PRIO_W-1:0] prio
    );
        logic [bpq_pkg::CLASS_W-1:0] c;
        c = 3'd1;
        if (prio >= bpq_pkg::BAND5_MIN)
            c = 3'd5;
        else if (prio >= bpq_pkg::BAND4_MIN)
            c = 3'd4;
        else if (prio >= bpq_pkg::BAND3_MIN)
            c = 3'd3;
        else if (prio >= bpq_pkg::BAND2_MIN)
            c = 3'd2;
        return c;
    endfunction

    task automatic predict_request(input logic cmd,
                                   input logic signed [bpq_pkg::VALUE_W-1:0] value,
                                   input logic signed [bpq_pkg::PRIO_W-1:0] prio);
        queue_result_t r;
        int            best;
        r.value = '0;
        r.cls   = '0;
        if (cmd == bpq_pkg::CMD_INSERT)
        begin
            r.cls = class_of(prio);
            if (held_count >= DEPTH)
            begin
                r.status = bpq_pkg::ST_FULL;
            end
            else
            begin
                held_value[held_count] = value;
                held_class[held_count] = r.cls;
                held_count++;
                r.status = bpq_pkg::ST_INSERTED;
            end
        end
        else if (held_count == 0)
        begin
            r.status = bpq_pkg::ST_EMPTY;
        end
        else
        begin
            // strict compare keeps the oldest among equal classes
            best = 0;
            for (int i = 1; i < held_count; i++)
                if (held_class[i] > held_class[best])
                    best = i;
            r.status = bpq_pkg::ST_REMOVED;
            r.value  = held_value[best];
            r.cls    = held_class[best];
            for (int i = best; i + 1 < held_count; i++)
            begin
                held_value[i] = held_value[i + 1];
                held_class[i] = held_class[i + 1];
            end
            held_count--;
        end
        result_q.push_back(r);
    endtask

    function automatic int check_result(input bpq_pkg::status_t status,
                                        input logic signed [bpq_pkg::VALUE_W-1:0] value,
                                        input logic [bpq_pkg::CLASS_W-1:0] cls);
        queue_result_t want;
        int            bad;
        bad = 0;
        if (result_q.size() == 0)
        begin
            $display("%0t: unexpected result status %s value %0d class %0d",
                     $time, status.name(), value, cls);
            return 1;
        end
        want = result_q.pop_front();
        if (status !== want.status)
        begin
            $display("%0t: status expected %s actual %s", $time, want.status.name(),
                     status.name());
            bad++;
        end
        if (value !== want.value)
        begin
            $display("%0t: out_value expected %0d actual %0d", $time, want.value, value);
            bad++;
        end
        if (cls !== want.cls)
        begin
            $display("%0t: out_class expected %0d actual %0d", $time, want.cls, cls);
            bad++;
        end
        return bad;
    endfunction

    always @(posedge clk)
    begin : monitor
        int bad_now;
        bad_now = 0;
        if (!rst_n)
        begin
            held_count = 0;
            result_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(s_tuser[0], s_tdata[31:0], s_tdata[47:32]);
            if (m_tvalid && m_tready)
                bad_now = check_result(bpq_pkg::status_t'(m_tuser), m_tdata[31:0],
                                       m_tdata[34:32]);
            errors  <= errors + bad_now;
            pending <= result_q.size();
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;

    localparam int DEPTH        = bpq_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_ITEMS  = 150;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int errors;
    int pending;
    bit quiet      = 1'b0;
    int stall_left = 0;

    banded_priority_queue_unit #(.DEPTH(DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bpq_checker #(.DEPTH(DEPTH)) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (quiet)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= int'($urandom_range(0, 2));
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic cmd, input logic [bpq_pkg::VALUE_W-1:0] value,
                                input logic [bpq_pkg::PRIO_W-1:0] prio);
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= {prio, value};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            s_tdata  <= 48'({$urandom, $urandom});
            s_tuser  <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [bpq_pkg::PRIO_W-1:0]  prio;
        logic [bpq_pkg::VALUE_W-1:0] value;
        logic                        cmd;
        int                          insert_pct;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // delete on an empty queue
        send_request(bpq_pkg::CMD_DELETE, 32'h0, 16'h0);

        // fill to capacity across every band boundary; last two tie with class 5
        for (int k = 0; k < 16; k++)
        begin
            case (k)
                0:       prio = 16'h8000;
                1:       prio = 16'hffff;
                2:       prio = 16'd0;
                3:       prio = 16'd19;
                4:       prio = 16'd20;
                5:       prio = 16'd39;
                6:       prio = 16'd40;
                7:       prio = 16'd59;
                8:       prio = 16'd60;
                9:       prio = 16'd79;
                10:      prio = 16'd80;
                11:      prio = 16'd99;
                12:      prio = 16'd100;
                13:      prio = 16'h7fff;
                14:      prio = 16'd85;
                default: prio = 16'd90;
            endcase
            case (k)
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = 32'hffff_ffff;
                3:       value = 32'h0;
                default: value = 32'(k * 1111);
            endcase
            send_request(bpq_pkg::CMD_INSERT, value, prio);
        end

        // insert on a full queue, then drain class 5 oldest first and the oldest class 4 entry
        send_request(bpq_pkg::CMD_INSERT, 32'h1234_5678, 16'd50);
        repeat (7) send_request(bpq_pkg::CMD_DELETE, $urandom, 16'($urandom));

        insert_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // insert bias shifts so the queue swings between empty and full
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    2:       insert_pct = 75;
                    default: insert_pct = 90;
                endcase
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            cmd   = ($urandom_range(0, 99) < insert_pct) ? bpq_pkg::CMD_INSERT
                                                         : bpq_pkg::CMD_DELETE;
            value = $urandom;
            if ($urandom_range(0, 9) == 0)
            begin
                prio = 16'($urandom);
            end
            else
            begin
                prio = 16'($urandom_range(0, 130));
                prio = prio - 16'd15;
            end
            send_request(cmd, value, prio);
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
